// ===== src/sdq_pkg.sv =====
// Shared types, palette and dither tables for the six-color dither quantizer.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps
package sdq_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] MODE_FASTEST = 2'd0;
  localparam logic [1:0] MODE_FAST    = 2'd1;
  localparam logic [1:0] MODE_TEXT    = 2'd2;
  localparam logic [1:0] MODE_QUALITY = 2'd3;

  localparam logic [12:0] ROLL_Y     = 13'd6192;
  localparam logic [11:0] ROLL_X     = 12'd3683;
  localparam logic [13:0] ROLL_MOD   = 14'd16383;
  localparam logic [13:0] ROLL_THIRD = 14'd5461;

  localparam logic [3:0] CODE_WHITE = 4'd1;

  typedef logic signed [10:0] pix_t;

  typedef enum logic [1:0] {
    K_LEFT,
    K_RIGHT,
    K_PAD_WHITE
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] mode;
    pix_t       r;
    pix_t       g;
    pix_t       b;
  } task_t;

  // 16x16 ordered matrix: bit pairs interleave col^row and col, MSB first.
  function automatic logic [7:0] bayer16(input logic [3:0] y, input logic [3:0] x);
    logic [7:0] t;
    begin
      t = 8'd0;
      for (int k = 0; k < 4; k++) begin
        t[7 - 2 * k] = x[k] ^ y[k];
        t[6 - 2 * k] = x[k];
      end
      return t;
    end
  endfunction

  // Residue modulo 2^14-1 of a 23-bit value.
  function automatic logic [13:0] fold_mod(input logic [22:0] x);
    logic [14:0] v;
    logic [13:0] w;
    begin
      v = {1'b0, x[13:0]} + {6'd0, x[22:14]};
      w = v[13:0] + {13'd0, v[14]};
      return (w == ROLL_MOD) ? 14'd0 : w;
    end
  endfunction

  function automatic logic [7:0] pal_level(input logic [2:0] idx, input logic [1:0] ch);
    logic [7:0] l;
    begin
      l = 8'd0;
      case (ch)
        2'd0: l = (idx == 3'd1 || idx == 3'd2 || idx == 3'd3) ? 8'd255 : 8'd0;
        2'd1: l = (idx == 3'd1 || idx == 3'd2 || idx == 3'd5) ? 8'd255 : 8'd0;
        2'd2: l = (idx == 3'd1 || idx == 3'd4) ? 8'd255 : 8'd0;
        default: l = 8'd0;
      endcase
      return l;
    end
  endfunction

  function automatic logic [3:0] pal_code(input logic [2:0] idx);
    logic [3:0] c;
    begin
      case (idx)
        3'd0: c = 4'd0;
        3'd1: c = 4'd1;
        3'd2: c = 4'd2;
        3'd3: c = 4'd3;
        3'd4: c = 4'd5;
        3'd5: c = 4'd6;
        default: c = 4'd1;
      endcase
      return c;
    end
  endfunction

endpackage

// ===== src/sdq_front.sv =====
// Front end: accepts pixels, computes the dither bias over a few steps and
// pushes classified work into the queue. Depends on sdq_pkg.
`timescale 1ns / 1ps
module sdq_front import sdq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [9:0] row,
  input  logic [9:0] column,
  input  logic       row_end,
  input  logic [1:0] mode,
  output logic       push,
  output task_t      push_data,
  input  logic       full
);

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_FOLD, F_BASE, F_SCALE, F_SUM, F_PUSH
  } fstate_t;

  fstate_t state;
  logic [1:0] mode_q;
  logic [9:0] row_q;
  logic [10:0] pos_q;
  logic last_q, pad_q;
  kind_t kind_q;
  pix_t pr, pg, pb;
  logic [22:0] prod_row, prod_pos;
  logic signed [8:0] tt;
  logic [13:0] mr, mp;
  logic signed [15:0] br, bg, bb;
  logic signed [27:0] cm, sr, sg, sb;

  logic [11:0] pos1;
  logic [7:0] bay;
  logic signed [14:0] base_d, vg_d, vb_d;
  logic signed [16:0] bsum;
  logic signed [27:0] bias_b, common, add_r, add_g, add_b;
  logic signed [27:0] tt_w, br_w, bg_w, bb_w, bsum_w;

  assign pos1 = {1'b0, pos_q} + 12'd1;
  assign bay  = bayer16(row_q[3:0], pos_q[3:0]);
  assign in_ready = (state == F_IDLE);
  assign push = (state == F_PUSH) && !full;
  assign push_data = '{kind: kind_q, mode: mode_q, r: pr, g: pg, b: pb};

  always_comb begin
    base_d = $signed({1'b0, mr}) - $signed({1'b0, mp});
    if (base_d < 0) base_d = base_d + $signed({1'b0, ROLL_MOD});
    vg_d = base_d - $signed({1'b0, ROLL_THIRD});
    if (vg_d < 0) vg_d = vg_d + $signed({1'b0, ROLL_MOD});
    vb_d = vg_d - $signed({1'b0, ROLL_THIRD});
    if (vb_d < 0) vb_d = vb_d + $signed({1'b0, ROLL_MOD});
  end

  assign bsum   = 17'(br) + 17'(bg) + 17'(bb);
  assign tt_w   = 28'(tt);
  assign br_w   = 28'(br);
  assign bg_w   = 28'(bg);
  assign bb_w   = 28'(bb);
  assign bsum_w = 28'(bsum);
  assign bias_b = (mode_q == MODE_FASTEST) ? (sr >>> 9) : (sr >>> 8);
  assign common = cm >>> 16;
  assign add_r  = common + (sr >>> 16);
  assign add_g  = common + (sg >>> 16);
  assign add_b  = common + (sb >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      pad_q <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            row_q  <= row;
            pos_q  <= {1'b0, column};
            pr     <= pix_t'({3'd0, red});
            pg     <= pix_t'({3'd0, green});
            pb     <= pix_t'({3'd0, blue});
            last_q <= row_end;
            kind_q <= column[0] ? K_RIGHT : K_LEFT;
            pad_q  <= 1'b0;
            state  <= F_MUL;
          end
        end
        F_MUL: begin
          prod_row <= {13'd0, row_q} * {10'd0, ROLL_Y};
          prod_pos <= {11'd0, pos1} * {11'd0, ROLL_X};
          tt       <= 9'($signed({1'b0, bay, 1'b0}) - 10'sd255);
          state    <= F_FOLD;
        end
        F_FOLD: begin
          mr    <= fold_mod(prod_row);
          mp    <= fold_mod(prod_pos);
          state <= F_BASE;
        end
        F_BASE: begin
          br    <= 16'(base_d) * 16'sd2 - 16'sd16382;
          bg    <= 16'(vg_d) * 16'sd2 - 16'sd16382;
          bb    <= 16'(vb_d) * 16'sd2 - 16'sd16382;
          state <= F_SCALE;
        end
        F_SCALE: begin
          case (mode_q)
            MODE_FASTEST: sr <= (tt_w <<< 8) - (tt_w <<< 3);
            MODE_FAST:    sr <= (tt_w <<< 7) + (tt_w <<< 5);
            MODE_TEXT: begin
              cm <= bsum_w <<< 7;
              sr <= br_w <<< 7;
              sg <= bg_w <<< 7;
              sb <= bb_w <<< 7;
            end
            default: begin
              cm <= (bsum_w <<< 8) - (bsum_w <<< 3);
              sr <= (br_w <<< 8) - (br_w <<< 3);
              sg <= (bg_w <<< 8) - (bg_w <<< 3);
              sb <= (bb_w <<< 8) - (bb_w <<< 3);
            end
          endcase
          state <= F_SUM;
        end
        F_SUM: begin
          if (mode_q == MODE_FASTEST || mode_q == MODE_FAST) begin
            pr <= pr + bias_b[10:0];
            pg <= pg + bias_b[10:0];
            pb <= pb + bias_b[10:0];
          end else begin
            pr <= pr + add_r[10:0];
            pg <= pg + add_g[10:0];
            pb <= pb + add_b[10:0];
          end
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            if (kind_q == K_LEFT && last_q && !pad_q) begin
              pad_q <= 1'b1;
              case (mode_q)
                MODE_FASTEST: kind_q <= K_PAD_WHITE;
                MODE_FAST: begin
                  kind_q <= K_RIGHT;
                  pr <= '0;
                  pg <= '0;
                  pb <= '0;
                end
                default: begin
                  kind_q <= K_RIGHT;
                  pr <= 11'sd128;
                  pg <= 11'sd128;
                  pb <= 11'sd128;
                  pos_q <= pos_q + 11'd1;
                  state <= F_MUL;
                end
              endcase
            end else begin
              state <= F_IDLE;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sdq_queue.sv =====
// Short request queue between the front end and the color search.
// Depends on sdq_pkg for the entry type and depth.
`timescale 1ns / 1ps
module sdq_queue import sdq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  task_t push_data,
  output logic  full,
  input  logic  pop,
  output task_t head,
  output logic  empty
);

  task_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0] count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/sdq_back.sv =====
// Back end: holds the left pixel, runs nearest-color and pair searches one
// channel term per cycle, and drives the output register. Depends on sdq_pkg.
`timescale 1ns / 1ps
module sdq_back import sdq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  task_t      head,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] packed_pair
);

  typedef enum logic [1:0] {B_IDLE, B_RUN, B_FIN} bstate_t;

  bstate_t state;
  pix_t held_r, held_g, held_b;
  logic [3:0] held_code;
  pix_t a_r, a_g, a_b, b_r, b_g, b_b;
  kind_t kind_q;
  logic single, first;
  logic [2:0] i, j, bi, bj;
  logic [1:0] c;
  logic [23:0] acc, best;

  pix_t av, bv;
  logic signed [11:0] e0, e1, es;
  logic signed [23:0] q0, q1, qs;
  logic [23:0] term, total;
  logic last_idx;

  always_comb begin
    case (c)
      2'd0:    begin av = a_r; bv = b_r; end
      2'd1:    begin av = a_g; bv = b_g; end
      default: begin av = a_b; bv = b_b; end
    endcase
  end

  assign e0 = 12'(av) - $signed({4'd0, pal_level(i, c)});
  assign e1 = 12'(bv) - $signed({4'd0, pal_level(j, c)});
  assign es = e0 + e1;
  assign q0 = 24'(e0) * 24'(e0);
  assign q1 = 24'(e1) * 24'(e1);
  assign qs = 24'(es) * 24'(es);
  assign term  = single ? 24'(q0) : 24'(q0 + q1 + qs);
  assign total = acc + term;
  assign last_idx = single ? (i == 3'd5) : (i == 3'd5 && j == 3'd5);
  assign pop = (state == B_IDLE) && !empty && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      held_r    <= '0;
      held_g    <= '0;
      held_b    <= '0;
      held_code <= CODE_WHITE;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (pop) begin
            kind_q <= head.kind;
            i <= '0;
            j <= '0;
            c <= '0;
            acc <= '0;
            first <= 1'b1;
            case (head.kind)
              K_LEFT: begin
                held_r <= head.r;
                held_g <= head.g;
                held_b <= head.b;
                a_r <= head.r;
                a_g <= head.g;
                a_b <= head.b;
                single <= 1'b1;
                state <= B_RUN;
              end
              K_RIGHT: begin
                if (head.mode == MODE_FASTEST) begin
                  a_r <= head.r;
                  a_g <= head.g;
                  a_b <= head.b;
                  single <= 1'b1;
                end else begin
                  a_r <= held_r;
                  a_g <= held_g;
                  a_b <= held_b;
                  b_r <= head.r;
                  b_g <= head.g;
                  b_b <= head.b;
                  single <= 1'b0;
                end
                state <= B_RUN;
              end
              default: begin
                packed_pair <= {held_code, CODE_WHITE};
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        B_RUN: begin
          if (c == 2'd2) begin
            c <= '0;
            acc <= '0;
            if (first || total < best) begin
              best <= total;
              bi <= i;
              bj <= j;
            end
            first <= 1'b0;
            if (last_idx) begin
              state <= B_FIN;
            end else if (!single && j != 3'd5) begin
              j <= j + 3'd1;
            end else begin
              j <= '0;
              i <= i + 3'd1;
            end
          end else begin
            c <= c + 2'd1;
            acc <= total;
          end
        end
        B_FIN: begin
          if (kind_q == K_LEFT) begin
            held_code <= pal_code(bi);
          end else begin
            packed_pair <= single ? {held_code, pal_code(bi)}
                                  : {pal_code(bi), pal_code(bj)};
            out_valid <= 1'b1;
          end
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == B_IDLE && !out_valid))
    else $error("request taken while search busy or result pending");
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_RUN) |-> (i < 3'd6 && j < 3'd6 && c != 2'd3))
    else $error("search index out of range");
  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    (state == B_FIN && kind_q != K_LEFT) |=> out_valid)
    else $error("finished search gave no result");
  a_left_silent: assert property (@(posedge clk) disable iff (rst)
    (state == B_FIN && kind_q == K_LEFT && !out_valid) |=> !out_valid)
    else $error("left pixel produced a result");
`endif

endmodule

// ===== src/six_color_dither_quantizer.sv =====
// Top level of the six-color ordered-dither quantizer: mode register,
// front end, request queue and color search. Depends on sdq_pkg and submodules.
//
//  channel   signals                                   direction
//  input     in_valid/in_ready, red green blue row
//            column row_end                            in
//  output    out_valid/out_ready, packed_pair          out
//  config    mode_write, mode_data                     in
//
// Front end: multiply, fold, base, scale, sum and push steps per pixel, rerun
// for a text/quality row-end gray pad. Search: 6 colors x 3 channel terms per
// left or fastest-mode right pixel, 36 pairs x 3 per pair; a white pad needs no
// search. A pending byte holds the search until taken. Reset clears control
// state; mode resets to quality, held code to white. A stalled output holds the
// search; the queue keeps the front end moving until it is full.
`timescale 1ns / 1ps
module six_color_dither_quantizer import sdq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [9:0] row,
  input  logic [9:0] column,
  input  logic       row_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] packed_pair,
  input  logic       mode_write,
  input  logic [1:0] mode_data
);

  logic [1:0] dither_mode;
  logic push, full, pop, empty;
  task_t push_data, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      dither_mode <= MODE_QUALITY;
    end else if (mode_write) begin
      dither_mode <= mode_data;
    end
  end

  sdq_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .red(red), .green(green), .blue(blue), .row(row), .column(column),
    .row_end(row_end), .mode(dither_mode), .push(push),
    .push_data(push_data), .full(full)
  );

  sdq_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .head(head), .empty(empty)
  );

  sdq_back u_back (
    .clk(clk), .rst(rst), .head(head), .empty(empty), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .packed_pair(packed_pair)
  );

endmodule
